### rtl/llgd_pkg.sv
// Shared types and constants for the damping relaxation step block.
// Used by every module of the block; depends on nothing else.
package llgd_pkg;

  localparam int MAG_W   = 24;
  localparam int ALPHA_W = 17;
  localparam int GAIN_W  = 32;
  localparam int THR_W   = 26;
  localparam int SQ_W    = 52;
  localparam int DS_A_W  = 64;
  localparam int DS_B_W  = 36;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  typedef enum logic [1:0] {
    REG_STEP_GAIN     = 2'd0,
    REG_DEFAULT_ALPHA = 2'd1,
    REG_TORQUE_THR    = 2'd2
  } reg_idx_t;

  // One queued cell with its damping already chosen.
  typedef struct packed {
    logic [MAG_W-1:0]   mag_x;
    logic [MAG_W-1:0]   mag_y;
    logic [MAG_W-1:0]   mag_z;
    logic [MAG_W-1:0]   field_x;
    logic [MAG_W-1:0]   field_y;
    logic [MAG_W-1:0]   field_z;
    logic [ALPHA_W-1:0] alpha;
    logic               last_cell;
  } cell_t;

  // Request to the shared divide and square root unit.
  typedef struct packed {
    logic              start;
    logic              sqrt;
    logic [DS_A_W-1:0] opa;
    logic [DS_B_W-1:0] opb;
  } ds_req_t;

endpackage

### rtl/llgd_front.sv
// Front end: takes cells from the input channel and picks their damping.
// Depends on llgd_pkg; feeds llgd_fifo.
module llgd_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [llgd_pkg::MAG_W-1:0]   in_mag_x,
  input  logic [llgd_pkg::MAG_W-1:0]   in_mag_y,
  input  logic [llgd_pkg::MAG_W-1:0]   in_mag_z,
  input  logic [llgd_pkg::MAG_W-1:0]   in_field_x,
  input  logic [llgd_pkg::MAG_W-1:0]   in_field_y,
  input  logic [llgd_pkg::MAG_W-1:0]   in_field_z,
  input  logic [llgd_pkg::ALPHA_W-1:0] in_cell_alpha,
  input  logic                         in_use_cell_alpha,
  input  logic                         in_last_cell,
  input  logic [llgd_pkg::ALPHA_W-1:0] default_alpha,
  input  logic                         q_full,
  output logic                         q_push,
  output llgd_pkg::cell_t              q_wdata
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.mag_x     = in_mag_x;
    q_wdata.mag_y     = in_mag_y;
    q_wdata.mag_z     = in_mag_z;
    q_wdata.field_x   = in_field_x;
    q_wdata.field_y   = in_field_y;
    q_wdata.field_z   = in_field_z;
    q_wdata.alpha     = in_use_cell_alpha ? in_cell_alpha : default_alpha;
    q_wdata.last_cell = in_last_cell;
  end

endmodule

### rtl/llgd_fifo.sv
// Two-entry queue between the front end and the compute sequencer.
// Depends on llgd_pkg for the cell type.
module llgd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  llgd_pkg::cell_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output llgd_pkg::cell_t rdata
);

  llgd_pkg::cell_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/llgd_divsqrt.sv
// Shared bit-serial unit: restoring division (one quotient bit per cycle)
// or integer square root (one root bit per cycle). Depends on llgd_pkg.
module llgd_divsqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  llgd_pkg::ds_req_t           req,
  output logic                        done,
  output logic [llgd_pkg::DS_A_W-1:0] result
);

  logic                        busy_r;
  logic                        done_r;
  logic                        mode_r;
  logic [5:0]                  cnt_r;
  logic [llgd_pkg::DS_A_W-1:0] acc_r;
  logic [37:0]                 rem_r;
  logic [llgd_pkg::DS_A_W-1:0] quo_r;
  logic [llgd_pkg::DS_B_W-1:0] dvs_r;

  logic [37:0] rem_sh;
  logic [37:0] trial;
  logic        ge;
  logic [37:0] rem_nxt;
  logic [llgd_pkg::DS_A_W-1:0] acc_nxt;

  always_comb begin
    if (mode_r) begin
      rem_sh  = {rem_r[35:0], acc_r[63:62]};
      trial   = {4'b0, quo_r[31:0], 2'b01};
      acc_nxt = {acc_r[61:0], 2'b00};
    end else begin
      rem_sh  = {rem_r[36:0], acc_r[63]};
      trial   = {2'b0, dvs_r};
      acc_nxt = {acc_r[62:0], 1'b0};
    end
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  assign done   = done_r;
  assign result = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.sqrt;
      cnt_r  <= req.sqrt ? 6'd31 : 6'd63;
      acc_r  <= req.opa;
      rem_r  <= '0;
      quo_r  <= '0;
      dvs_r  <= req.opb;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      quo_r <= {quo_r[62:0], ge};
    end
  end

endmodule

### rtl/llgd_back.sv
// Back end: sequencer that carries out the damping step for one cell with
// one shared 33x33 multiplier and the llgd_divsqrt unit. Depends on llgd_pkg.
module llgd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  llgd_pkg::cell_t              q_data,
  output logic                         q_pop,
  input  logic [llgd_pkg::GAIN_W-1:0]  step_gain,
  input  logic [llgd_pkg::THR_W-1:0]   torque_thr,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [llgd_pkg::MAG_W-1:0]   new_mag_x,
  output logic [llgd_pkg::MAG_W-1:0]   new_mag_y,
  output logic [llgd_pkg::MAG_W-1:0]   new_mag_z,
  output logic [llgd_pkg::THR_W-1:0]   max_torque_mag,
  output logic                         converged,
  output logic                         pass_done
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_ALPHA  = 16'h0002,
    S_FDIV   = 16'h0004,
    S_GAIN   = 16'h0008,
    S_CROSS  = 16'h0010,
    S_TORQ   = 16'h0020,
    S_DCROSS = 16'h0040,
    S_SCALE  = 16'h0080,
    S_NORM   = 16'h0100,
    S_SUMSQ  = 16'h0200,
    S_LEN    = 16'h0400,
    S_OUT    = 16'h0800,
    S_OWAIT  = 16'h1000,
    S_FIN    = 16'h2000,
    S_TWAIT  = 16'h4000,
    S_DONE   = 16'h8000
  } state_t;

  function automatic logic [1:0] lane_p(logic [1:0] j);
    logic [1:0] p;
    unique case (j)
      2'd0:    p = 2'd1;
      2'd1:    p = 2'd2;
      2'd2:    p = 2'd0;
      default: p = 2'd1;
    endcase
    return p;
  endfunction

  function automatic logic [1:0] lane_q(logic [1:0] j);
    logic [1:0] q;
    unique case (j)
      2'd0:    q = 2'd2;
      2'd1:    q = 2'd0;
      2'd2:    q = 2'd1;
      default: q = 2'd2;
    endcase
    return q;
  endfunction

  function automatic logic signed [32:0] sx24(logic [23:0] v);
    return {{9{v[23]}}, v};
  endfunction

  state_t state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;

  llgd_pkg::cell_t      cell_r;
  logic [15:0]          f_r;
  logic [31:0]          k_r;
  logic signed [48:0]   c_r [3];
  logic [51:0]          sq_r;
  logic [51:0]          max_r;
  logic signed [61:0]   d_r [3];
  logic [31:0]          tmp_r;
  logic                 neg_r [3];
  logic [49:0]          mg_r [3];
  logic [61:0]          s_r;
  logic [31:0]          len_r;
  logic [23:0]          onew_r [3];
  logic [25:0]          tm_r;
  logic                 conv_r;
  logic signed [65:0]   prod_r;

  logic signed [32:0]   mul_a, mul_b;
  logic [23:0]          m_w [3];
  logic [23:0]          h_w [3];
  logic [48:0]          c_mag [3];
  logic [26:0]          t_w [3];
  logic [37:0]          r_mag [3];
  logic signed [38:0]   r_s [3];
  logic [61:0]          d_mag [3];
  logic [3:0]           rix;
  logic [1:0]           ij, ip, iq;
  logic [1:0]           rj;
  logic [51:0]          sq_fin;
  logic [61:0]          s_fin;
  logic signed [61:0]   dterm;
  logic [60:0]          scale_sum;
  logic signed [50:0]   v_s;
  logic [49:0]          v_mag;
  logic [49:0]          mx;
  logic [23:0]          q_res;

  llgd_pkg::ds_req_t    ds_req;
  logic                 ds_done;
  logic [llgd_pkg::DS_A_W-1:0] ds_result;

  llgd_divsqrt u_divsqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ds_req),
    .done   (ds_done),
    .result (ds_result)
  );

  assign m_w[0] = cell_r.mag_x;
  assign m_w[1] = cell_r.mag_y;
  assign m_w[2] = cell_r.mag_z;
  assign h_w[0] = cell_r.field_x;
  assign h_w[1] = cell_r.field_y;
  assign h_w[2] = cell_r.field_z;

  // Per-lane views of the cross products: magnitudes, torque terms and the
  // reduced cross product split into a signed high part and unsigned low part.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_mag[i] = c_r[i][48] ? 49'(-c_r[i]) : 49'(c_r[i]);
      t_w[i]   = c_mag[i][48:22];
      r_mag[i] = c_mag[i][48:11];
      r_s[i]   = c_r[i][48] ? -$signed({1'b0, r_mag[i]}) : $signed({1'b0, r_mag[i]});
      d_mag[i] = d_r[i][61] ? 62'(-d_r[i]) : 62'(d_r[i]);
    end
  end

  assign rix    = idx_r - 4'd1;
  assign sq_fin = sq_r + prod_r[51:0];
  assign s_fin  = s_r + prod_r[61:0];
  assign dterm  = rix[0] ? prod_r[61:0] : {prod_r[43:0], 18'b0};
  assign rj     = rix[2:1];

  always_comb begin
    scale_sum = prod_r[60:0] + {29'b0, tmp_r};
    if (d_r[rj][61]) begin
      v_s = {{27{m_w[rj][23]}}, m_w[rj]} + {1'b0, scale_sum[60:11]};
    end else begin
      v_s = {{27{m_w[rj][23]}}, m_w[rj]} - {1'b0, scale_sum[60:11]};
    end
    v_mag = v_s[50] ? 50'(-v_s) : 50'(v_s);
  end

  always_comb begin
    mx = mg_r[0];
    if (mg_r[1] > mx) mx = mg_r[1];
    if (mg_r[2] > mx) mx = mg_r[2];
  end

  assign q_res = ds_result[23:0];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    ij    = 2'd0;
    ip    = 2'd1;
    iq    = 2'd2;
    unique case (state_r)
      S_ALPHA: begin
        mul_a = {16'b0, cell_r.alpha};
        mul_b = {16'b0, cell_r.alpha};
      end
      S_GAIN: begin
        mul_a = {1'b0, step_gain};
        mul_b = {17'b0, f_r};
      end
      S_CROSS: begin
        ij = idx_r[2:1];
        ip = lane_p(ij);
        iq = lane_q(ij);
        if (idx_r < 4'd6) begin
          if (!idx_r[0]) begin
            mul_a = sx24(m_w[ip]);
            mul_b = sx24(h_w[iq]);
          end else begin
            mul_a = sx24(m_w[iq]);
            mul_b = sx24(h_w[ip]);
          end
        end
      end
      S_TORQ: begin
        if (idx_r < 4'd3) begin
          mul_a = {6'b0, t_w[idx_r[1:0]]};
          mul_b = {6'b0, t_w[idx_r[1:0]]};
        end
      end
      S_DCROSS: begin
        ij = idx_r[3:2];
        ip = lane_p(ij);
        iq = lane_q(ij);
        if (idx_r < 4'd12) begin
          unique case (idx_r[1:0])
            2'd0: begin
              mul_a = sx24(m_w[ip]);
              mul_b = {{12{r_s[iq][38]}}, r_s[iq][38:18]};
            end
            2'd1: begin
              mul_a = sx24(m_w[ip]);
              mul_b = {15'b0, r_s[iq][17:0]};
            end
            2'd2: begin
              mul_a = sx24(m_w[iq]);
              mul_b = {{12{r_s[ip][38]}}, r_s[ip][38:18]};
            end
            default: begin
              mul_a = sx24(m_w[iq]);
              mul_b = {15'b0, r_s[ip][17:0]};
            end
          endcase
        end
      end
      S_SCALE: begin
        ij = idx_r[2:1];
        if (idx_r < 4'd6) begin
          mul_a = idx_r[0] ? {4'b0, d_mag[ij][60:32]} : {1'b0, d_mag[ij][31:0]};
          mul_b = {1'b0, k_r};
        end
      end
      S_SUMSQ: begin
        if (idx_r < 4'd3) begin
          mul_a = {3'b0, mg_r[idx_r[1:0]][29:0]};
          mul_b = {3'b0, mg_r[idx_r[1:0]][29:0]};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ds_req = '0;
    unique case (state_r)
      S_ALPHA: begin
        if (idx_r == 4'd1) begin
          ds_req.start = 1'b1;
          ds_req.opa   = {15'b0, cell_r.alpha, 32'b0};
          ds_req.opb   = {2'b0, prod_r[33:0]} + 36'h1_0000_0000;
        end
      end
      S_SUMSQ: begin
        if (idx_r == 4'd3) begin
          ds_req.start = 1'b1;
          ds_req.sqrt  = 1'b1;
          ds_req.opa   = {2'b0, s_fin};
        end
      end
      S_OUT: begin
        ds_req.start = 1'b1;
        ds_req.opa   = {12'b0, mg_r[idx_r[1:0]][29:0], 22'b0} + {33'b0, len_r[31:1]};
        ds_req.opb   = {4'b0, len_r};
      end
      S_FIN: begin
        if (cell_r.last_cell) begin
          ds_req.start = 1'b1;
          ds_req.sqrt  = 1'b1;
          ds_req.opa   = {12'b0, max_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_ALPHA;
          idx_nxt   = 4'd0;
        end
      end
      S_ALPHA: begin
        if (idx_r == 4'd1) state_nxt = S_FDIV;
        else idx_nxt = idx_r + 4'd1;
      end
      S_FDIV: begin
        if (ds_done) begin
          state_nxt = S_GAIN;
          idx_nxt   = 4'd0;
        end
      end
      S_GAIN: begin
        if (idx_r == 4'd1) begin
          state_nxt = S_CROSS;
          idx_nxt   = 4'd0;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      S_CROSS: begin
        if (idx_r == 4'd6) begin
          state_nxt = S_TORQ;
          idx_nxt   = 4'd0;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      S_TORQ: begin
        if (idx_r == 4'd3) begin
          state_nxt = S_DCROSS;
          idx_nxt   = 4'd0;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      S_DCROSS: begin
        if (idx_r == 4'd12) begin
          state_nxt = S_SCALE;
          idx_nxt   = 4'd0;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      S_SCALE: begin
        if (idx_r == 4'd6) state_nxt = S_NORM;
        else idx_nxt = idx_r + 4'd1;
      end
      S_NORM: begin
        if (mx == '0) begin
          state_nxt = S_FIN;
        end else if (mx[49:30] == '0 && mx[29]) begin
          state_nxt = S_SUMSQ;
          idx_nxt   = 4'd0;
        end
      end
      S_SUMSQ: begin
        if (idx_r == 4'd3) state_nxt = S_LEN;
        else idx_nxt = idx_r + 4'd1;
      end
      S_LEN: begin
        if (ds_done) begin
          state_nxt = S_OUT;
          idx_nxt   = 4'd0;
        end
      end
      S_OUT: begin
        state_nxt = S_OWAIT;
      end
      S_OWAIT: begin
        if (ds_done) begin
          if (idx_r == 4'd2) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_OUT;
            idx_nxt   = idx_r + 4'd1;
          end
        end
      end
      S_FIN: begin
        state_nxt = cell_r.last_cell ? S_TWAIT : S_DONE;
      end
      S_TWAIT: begin
        if (ds_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 4'd0;
      max_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (state_r == S_TORQ && idx_r == 4'd3 && sq_fin > max_r) begin
        max_r <= sq_fin;
      end else if (state_r == S_TWAIT && ds_done) begin
        max_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) cell_r <= q_data;
      end
      S_FDIV: begin
        if (ds_done) f_r <= ds_result[15:0];
      end
      S_GAIN: begin
        if (idx_r == 4'd1) k_r <= prod_r[47:16];
      end
      S_CROSS: begin
        if (idx_r != 4'd0) begin
          if (!rix[0]) c_r[rix[2:1]] <= prod_r[48:0];
          else c_r[rix[2:1]] <= c_r[rix[2:1]] - prod_r[48:0];
        end
      end
      S_TORQ: begin
        if (idx_r == 4'd1) sq_r <= prod_r[51:0];
        else if (idx_r == 4'd2) sq_r <= sq_fin;
      end
      S_DCROSS: begin
        if (idx_r != 4'd0) begin
          unique case (rix[1:0])
            2'd0:    d_r[rix[3:2]] <= dterm;
            2'd1:    d_r[rix[3:2]] <= d_r[rix[3:2]] + dterm;
            default: d_r[rix[3:2]] <= d_r[rix[3:2]] - dterm;
          endcase
        end
      end
      S_SCALE: begin
        if (idx_r != 4'd0) begin
          if (!rix[0]) begin
            tmp_r <= prod_r[63:32];
          end else begin
            neg_r[rj] <= v_s[50];
            mg_r[rj]  <= v_mag;
          end
        end
      end
      S_NORM: begin
        if (mx == '0) begin
          for (int i = 0; i < 3; i++) onew_r[i] <= '0;
        end else if (mx[49:30] != '0) begin
          for (int i = 0; i < 3; i++) mg_r[i] <= {1'b0, mg_r[i][49:1]};
        end else if (!mx[29]) begin
          for (int i = 0; i < 3; i++) mg_r[i] <= {mg_r[i][48:0], 1'b0};
        end
      end
      S_SUMSQ: begin
        if (idx_r == 4'd1) s_r <= prod_r[61:0];
        else if (idx_r == 4'd2) s_r <= s_fin;
      end
      S_LEN: begin
        if (ds_done) len_r <= ds_result[31:0];
      end
      S_OWAIT: begin
        if (ds_done) begin
          onew_r[idx_r[1:0]] <= neg_r[idx_r[1:0]] ? -q_res : q_res;
        end
      end
      S_FIN: begin
        if (!cell_r.last_cell) begin
          tm_r   <= '0;
          conv_r <= 1'b0;
        end
      end
      S_TWAIT: begin
        if (ds_done) begin
          tm_r   <= ds_result[25:0];
          conv_r <= (ds_result[25:0] < torque_thr);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = (state_r == S_DONE);
  assign new_mag_x      = onew_r[0];
  assign new_mag_y      = onew_r[1];
  assign new_mag_z      = onew_r[2];
  assign max_torque_mag = tm_r;
  assign converged      = conv_r;
  assign pass_done      = cell_r.last_cell;

endmodule

### rtl/llg_damping_relax_step.sv
// The back end works on one cell at a time, from taking it off the queue until
// its result is offered, and any result may then wait on out_stall. Most of
// the time goes to the bit-serial divide and square root unit: one 64-step
// divide for the damping factor, one 32-step root for the vector length, three
// more 64-step divides for the renormalized components, and one more 32-step
// root on the last cell of a pass. The renormalizing shift moves one bit per
// cycle, for as many bits as the size of the stepped vector requires. A cell
// whose stepped vector is zero skips the renormalization. The back end takes
// the next cell in the cycle after the output transaction. A two-entry queue
// takes new cells while a result waits on the output; the result registers
// hold until the transaction on the output completes.
// Registers sit at byte addresses 0, 4 and 8.
// Depends on llgd_pkg, llgd_front, llgd_fifo and llgd_back.
module llg_damping_relax_step (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [llgd_pkg::MAG_W-1:0]   in_mag_x,
  input  logic [llgd_pkg::MAG_W-1:0]   in_mag_y,
  input  logic [llgd_pkg::MAG_W-1:0]   in_mag_z,
  input  logic [llgd_pkg::MAG_W-1:0]   in_field_x,
  input  logic [llgd_pkg::MAG_W-1:0]   in_field_y,
  input  logic [llgd_pkg::MAG_W-1:0]   in_field_z,
  input  logic [llgd_pkg::ALPHA_W-1:0] in_cell_alpha,
  input  logic                         in_use_cell_alpha,
  input  logic                         in_last_cell,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [llgd_pkg::MAG_W-1:0]   out_new_mag_x,
  output logic [llgd_pkg::MAG_W-1:0]   out_new_mag_y,
  output logic [llgd_pkg::MAG_W-1:0]   out_new_mag_z,
  output logic [llgd_pkg::THR_W-1:0]   out_max_torque_mag,
  output logic                         out_converged,
  output logic                         out_pass_done
);

  logic [llgd_pkg::GAIN_W-1:0]  step_gain_r;
  logic [llgd_pkg::ALPHA_W-1:0] default_alpha_r;
  logic [llgd_pkg::THR_W-1:0]   torque_thr_r;

  logic            q_full, q_push, q_pop, q_valid;
  llgd_pkg::cell_t q_wdata, q_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_gain_r     <= '0;
      default_alpha_r <= llgd_pkg::ALPHA_ONE;
      torque_thr_r    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        llgd_pkg::REG_STEP_GAIN:     step_gain_r     <= pwdata;
        llgd_pkg::REG_DEFAULT_ALPHA: default_alpha_r <= pwdata[16:0];
        llgd_pkg::REG_TORQUE_THR:    torque_thr_r    <= pwdata[25:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      llgd_pkg::REG_STEP_GAIN:     prdata = step_gain_r;
      llgd_pkg::REG_DEFAULT_ALPHA: prdata = {15'b0, default_alpha_r};
      llgd_pkg::REG_TORQUE_THR:    prdata = {6'b0, torque_thr_r};
      default:                     prdata = '0;
    endcase
  end

  llgd_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mag_x          (in_mag_x),
    .in_mag_y          (in_mag_y),
    .in_mag_z          (in_mag_z),
    .in_field_x        (in_field_x),
    .in_field_y        (in_field_y),
    .in_field_z        (in_field_z),
    .in_cell_alpha     (in_cell_alpha),
    .in_use_cell_alpha (in_use_cell_alpha),
    .in_last_cell      (in_last_cell),
    .default_alpha     (default_alpha_r),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_wdata           (q_wdata)
  );

  llgd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  llgd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .step_gain      (step_gain_r),
    .torque_thr     (torque_thr_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .new_mag_x      (out_new_mag_x),
    .new_mag_y      (out_new_mag_y),
    .new_mag_z      (out_new_mag_z),
    .max_torque_mag (out_max_torque_mag),
    .converged      (out_converged),
    .pass_done      (out_pass_done)
  );

endmodule

### rtl/llgd_checker.sv
// Port-level checks for llg_damping_relax_step, attached by the bind below.
// Depends on llgd_pkg and on the top level's port list.
module llgd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [llgd_pkg::MAG_W-1:0]   out_new_mag_x,
  input logic [llgd_pkg::MAG_W-1:0]   out_new_mag_y,
  input logic [llgd_pkg::MAG_W-1:0]   out_new_mag_z,
  input logic [llgd_pkg::THR_W-1:0]   out_max_torque_mag,
  input logic                         out_converged,
  input logic                         out_pass_done
);

  // A stalled result keeps its whole payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_mag_x) &&
      $stable(out_new_mag_y) && $stable(out_new_mag_z) &&
      $stable(out_max_torque_mag) && $stable(out_converged) && $stable(out_pass_done))
    else $error("result changed while stalled");

  // Torque report and convergence flag only travel with the last cell.
  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pass_done |-> out_max_torque_mag == '0 && !out_converged)
    else $error("torque report outside the last cell");

  // Renormalized components never exceed unit length.
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_new_mag_x) <= 24'sd4194304 &&
      $signed(out_new_mag_x) >= -24'sd4194304 &&
      $signed(out_new_mag_y) <= 24'sd4194304 &&
      $signed(out_new_mag_y) >= -24'sd4194304 &&
      $signed(out_new_mag_z) <= 24'sd4194304 &&
      $signed(out_new_mag_z) >= -24'sd4194304)
    else $error("component above unit length");

  // No result is offered in the cycle after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind llg_damping_relax_step llgd_checker u_llgd_checker (.*);
